/* hdl/crc16_nibble_check_core_assert.svh */
// ----------------------------------------------------------------------------
// crc16_nibble_check_core_assert.svh
// Assertion macros shared by the CRC-16 nibble check core.
// Each macro expects aclk and aresetn in scope.
// ----------------------------------------------------------------------------
`ifndef CRC16_NIBBLE_CHECK_CORE_ASSERT_SVH
`define CRC16_NIBBLE_CHECK_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define CRC16NC_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("crc16nc: same-cycle check failed");

// Next-cycle implication, disabled during reset
`define CRC16NC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("crc16nc: next-cycle check failed");

`endif

/* hdl/crc16nc_pkg.sv */
// ----------------------------------------------------------------------------
// crc16nc_pkg
// Shared types, status codes and the nibble-wise CRC-16 (poly 0xA001,
// reflected) helpers for the CRC-16 nibble check core.
// ----------------------------------------------------------------------------
package crc16nc_pkg;

    localparam logic [15:0] CRC_START = 16'h55AA;

    typedef logic [1:0] status_t;

    localparam status_t ST_OK       = 2'd0;
    localparam status_t ST_MISMATCH = 2'd1;
    localparam status_t ST_SHORT    = 2'd2;

    // One input beat
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } item_t;

    // One result beat
    typedef struct packed {
        logic [15:0] crc_value;
        logic [15:0] stored_value;
        status_t     status;
    } result_t;

    // Control from the top level into the engine
    typedef struct packed {
        logic step;        // commit the item in the input register
        logic check_mode;  // current mode register
    } eng_ctrl_t;

    // 4-bit table step for the reflected polynomial 0xA001
    function automatic logic [15:0] nib_tab(input logic [3:0] idx);
        logic [15:0] val;
        unique case (idx)
            4'h0: val = 16'h0000;
            4'h1: val = 16'hCC01;
            4'h2: val = 16'hD801;
            4'h3: val = 16'h1400;
            4'h4: val = 16'hF001;
            4'h5: val = 16'h3C00;
            4'h6: val = 16'h2800;
            4'h7: val = 16'hE401;
            4'h8: val = 16'hA001;
            4'h9: val = 16'h6C00;
            4'hA: val = 16'h7800;
            4'hB: val = 16'hB401;
            4'hC: val = 16'h5000;
            4'hD: val = 16'h9C01;
            4'hE: val = 16'h8801;
            4'hF: val = 16'h4400;
            default: val = 16'h0000;
        endcase
        return val;
    endfunction

    // Fold one byte: low nibble first, then high nibble
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c1;
        logic [15:0] c2;
        c1 = (crc >> 4) ^ nib_tab(crc[3:0]) ^ nib_tab(b[3:0]);
        c2 = (c1 >> 4) ^ nib_tab(c1[3:0]) ^ nib_tab(b[7:4]);
        return c2;
    endfunction

endpackage

/* hdl/crc16_nibble_check_core.sv */
// A last byte goes through the input register, then the result register, to m_*.
// One byte per cycle unless stalled; the CRC fold of a byte (two table steps) is combinational.
// A non-last byte always moves on; a last byte waits in the input register while the
// result register holds an unread result, which stalls s_ready.
// Reset (aresetn low, synchronous): CRC back to 0x55AA, hold count zero, compute mode,
// both pipeline registers empty.
// ----------------------------------------------------------------------------
// crc16_nibble_check_core
// Streaming CRC-16 generator/checker, one byte per beat, with a check mode
// that compares the CRC against a trailing little-endian stored CRC.
// ----------------------------------------------------------------------------
`include "crc16_nibble_check_core_assert.svh"

module crc16_nibble_check_core
    import crc16nc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,
    // byte input
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_last_byte,
    // result output
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_crc_value,
    output logic [15:0] m_stored_value,
    output logic [1:0]  m_status
);

    logic      mode_reg;
    logic      in_vld_reg;
    item_t     in_item_reg;
    logic      out_vld_reg, out_vld_next;
    result_t   out_res_reg;
    result_t   eng_res;
    eng_ctrl_t eng_ctrl;
    logic      out_free;
    logic      advance;
    logic      res_short;
    logic      short_fields_ok;
    logic      res_check_ok;

    // Mode register
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= 1'b0;
        end else if (cfg_valid) begin
            mode_reg <= cfg_data;
        end
    end

    // Flow control: a non-last beat always moves on, a last beat needs a free result slot
    assign out_free = !out_vld_reg || m_ready;
    assign advance  = in_vld_reg && (!in_item_reg.last_byte || out_free);
    assign s_ready  = !in_vld_reg || advance;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg.data_byte <= s_data_byte;
            in_item_reg.last_byte <= s_last_byte;
        end
    end

    // Message state and fold logic
    assign eng_ctrl.step       = advance;
    assign eng_ctrl.check_mode = mode_reg;

    crc16nc_engine u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (eng_ctrl),
        .item    (in_item_reg),
        .result  (eng_res)
    );

    // Result register
    always_comb begin
        if (advance && in_item_reg.last_byte) begin
            out_vld_next = 1'b1;
        end else if (m_ready) begin
            out_vld_next = 1'b0;
        end else begin
            out_vld_next = out_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else begin
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_item_reg.last_byte) begin
            out_res_reg <= eng_res;
        end
    end

    assign m_valid        = out_vld_reg;
    assign m_crc_value    = out_res_reg.crc_value;
    assign m_stored_value = out_res_reg.stored_value;
    assign m_status       = out_res_reg.status;

    // Checks
    assign res_short       = m_valid && m_status == ST_SHORT;
    assign short_fields_ok = m_crc_value == CRC_START && m_stored_value == 16'h0000;
    assign res_check_ok    = m_valid && mode_reg && m_status == ST_OK;

    `CRC16NC_ASSERT_IMPL(a_status_code, m_valid, m_status <= ST_SHORT)
    `CRC16NC_ASSERT_IMPL(a_short_fields, res_short, short_fields_ok)
    `CRC16NC_ASSERT_IMPL(a_check_ok_match, res_check_ok, m_crc_value == m_stored_value)
    `CRC16NC_ASSERT_NEXT(a_last_gives_result, advance && in_item_reg.last_byte, m_valid)

endmodule

/* hdl/crc16nc_engine.sv */
// ----------------------------------------------------------------------------
// crc16nc_engine
// Message state (running CRC, two-byte hold buffer, hold count) and the
// combinational fold/compare logic for the item in the input register.
// ----------------------------------------------------------------------------
module crc16nc_engine
    import crc16nc_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  eng_ctrl_t ctrl,
    input  item_t     item,
    output result_t   result
);

    logic [15:0] crc_reg,   crc_next;
    logic [7:0]  held0_reg, held0_next;
    logic [7:0]  held1_reg, held1_next;
    logic [1:0]  cnt_reg,   cnt_next;

    logic [15:0] crc_mid;
    logic [15:0] fold_in;
    logic [7:0]  fold_byte;
    logic [1:0]  cnt_mid;

    // Pick the byte that enters the CRC this beat
    always_comb begin
        if (ctrl.check_mode) begin
            fold_byte = held0_reg;
        end else begin
            fold_byte = item.data_byte;
        end
        fold_in = crc_byte(crc_reg, fold_byte);
    end

    // Hold buffer update and CRC advance
    always_comb begin
        crc_mid    = crc_reg;
        held0_next = held0_reg;
        held1_next = held1_reg;
        cnt_mid    = cnt_reg;
        if (ctrl.check_mode) begin
            if (cnt_reg[1]) begin
                // buffer full: oldest byte is covered, shift down
                crc_mid    = fold_in;
                held0_next = held1_reg;
                held1_next = item.data_byte;
                cnt_mid    = 2'd2;
            end else if (cnt_reg[0]) begin
                held1_next = item.data_byte;
                cnt_mid    = 2'd2;
            end else begin
                held0_next = item.data_byte;
                cnt_mid    = 2'd1;
            end
        end else begin
            crc_mid = fold_in;
            cnt_mid = 2'd0;
        end
    end

    // Result for a last byte
    always_comb begin
        if (!ctrl.check_mode) begin
            result.crc_value    = crc_mid;
            result.stored_value = 16'h0000;
            result.status       = ST_OK;
        end else if (!cnt_mid[1]) begin
            result.crc_value    = CRC_START;
            result.stored_value = 16'h0000;
            result.status       = ST_SHORT;
        end else begin
            result.crc_value    = crc_mid;
            result.stored_value = {held1_next, held0_next};
            result.status       = (crc_mid == {held1_next, held0_next}) ? ST_OK : ST_MISMATCH;
        end
    end

    // Restart after every last byte
    always_comb begin
        if (item.last_byte) begin
            crc_next = CRC_START;
            cnt_next = 2'd0;
        end else begin
            crc_next = crc_mid;
            cnt_next = cnt_mid;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg <= CRC_START;
            cnt_reg <= 2'd0;
        end else if (ctrl.step) begin
            crc_reg <= crc_next;
            cnt_reg <= cnt_next;
        end
    end

    // Held bytes: payload, no reset
    always_ff @(posedge aclk) begin
        if (ctrl.step) begin
            held0_reg <= held0_next;
            held1_reg <= held1_next;
        end
    end

endmodule

/* verif/crc16_result_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// CRC-16 result checker
// Follows the config, byte and result channels of the CRC-16 nibble check
// core. It keeps its own copy of the running CRC, the trailing-byte hold
// buffer and the mode, and queues one expected result per last byte. Each
// result beat is compared field by field against the oldest entry.
// ----------------------------------------------------------------------------
package crc16_tb_pkg;

    localparam logic MODE_COMPUTE = 1'b0;
    localparam logic MODE_CHECK   = 1'b1;

    // Reflected CRC-16, poly 0xA001, one byte shifted in LSB first
    function automatic logic [15:0] crc_add_byte(input logic [15:0] crc,
                                                 input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
        end
        return c;
    endfunction

endpackage

module crc16_result_checker
    import crc16nc_pkg::*;
    import crc16_tb_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        cfg_data,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_last_byte,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [15:0] m_crc_value,
    input  logic [15:0] m_stored_value,
    input  logic [1:0]  m_status,
    output int          failures,
    output int          outstanding
);

    logic        mode;
    logic [15:0] crc_acc;
    logic [7:0]  tail_bytes [2];
    int          tail_cnt;
    result_t     result_q [$];
    int          errs = 0;

    assign failures = errs;

    task automatic report(input string what, input logic [15:0] got,
                          input logic [15:0] want);
        $display("%0t: %s: got %h, expected %h", $time, what, got, want);
        errs++;
    endtask

    // Fold one accepted byte into the shadow state; queue a result on last
    task automatic take_byte(input logic [7:0] b, input logic last);
        result_t r;
        if (mode == MODE_CHECK) begin
            if (tail_cnt == 2) begin
                // oldest held byte is no longer a trailer candidate
                crc_acc       = crc_add_byte(crc_acc, tail_bytes[0]);
                tail_bytes[0] = tail_bytes[1];
                tail_bytes[1] = b;
            end else begin
                tail_bytes[tail_cnt] = b;
                tail_cnt++;
            end
        end else begin
            crc_acc  = crc_add_byte(crc_acc, b);
            tail_cnt = 0;
        end

        if (last) begin
            if (mode == MODE_COMPUTE) begin
                r.crc_value    = crc_acc;
                r.stored_value = 16'h0000;
                r.status       = ST_OK;
            end else if (tail_cnt < 2) begin
                r.crc_value    = CRC_START;
                r.stored_value = 16'h0000;
                r.status       = ST_SHORT;
            end else begin
                r.crc_value    = crc_acc;
                r.stored_value = {tail_bytes[1], tail_bytes[0]};
                r.status       = (crc_acc == r.stored_value) ? ST_OK : ST_MISMATCH;
            end
            result_q.push_back(r);
            crc_acc  = CRC_START;
            tail_cnt = 0;
        end
    endtask

    // Sample all three channels at the edge
    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            mode     = MODE_COMPUTE;
            crc_acc  = CRC_START;
            tail_cnt = 0;
            result_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) mode = cfg_data;
            if (s_valid && s_ready) take_byte(s_data_byte, s_last_byte);
            if (m_valid && m_ready) begin
                if (result_q.size() == 0) begin
                    report("result beat with none pending, crc_value", m_crc_value, 16'h0);
                end else begin
                    want = result_q.pop_front();
                    if (m_crc_value !== want.crc_value)
                        report("crc_value", m_crc_value, want.crc_value);
                    if (m_stored_value !== want.stored_value)
                        report("stored_value", m_stored_value, want.stored_value);
                    if (m_status !== want.status)
                        report("status", {14'h0, m_status}, {14'h0, want.status});
                end
            end
        end
        outstanding <= result_q.size();
    end

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// CRC-16 nibble check core testbench
// Drives byte messages in compute and check mode, with valid/ready gaps on
// both sides and one long result back-pressure stretch. Directed messages
// cover short trailers, matches, mismatches and mode changes mid-message;
// in random check-mode blocks most messages are well-formed, plus noise.
// ----------------------------------------------------------------------------
module tb_top;
    import crc16nc_pkg::*;
    import crc16_tb_pkg::*;

    logic        aclk;
    logic        aresetn     = 1'b0;
    logic        cfg_valid   = 1'b0;
    logic        cfg_data    = 1'b0;
    logic        s_valid     = 1'b0;
    logic [7:0]  s_data_byte = 8'h00;
    logic        s_last_byte = 1'b0;
    logic        m_ready     = 1'b0;
    logic        cfg_ready;
    logic        s_ready;
    logic        m_valid;
    logic [15:0] m_crc_value;
    logic [15:0] m_stored_value;
    logic [1:0]  m_status;

    int   fail_cnt;
    int   pending;
    int   snd_idle_pct = 0;
    int   rcv_idle_pct = 0;
    int   stall_asked  = 0;
    int   stall_done   = 0;
    int   bytes_sent   = 0;
    logic cur_mode     = MODE_COMPUTE;

    crc16_nibble_check_core u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_byte    (s_data_byte),
        .s_last_byte    (s_last_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_crc_value    (m_crc_value),
        .m_stored_value (m_stored_value),
        .m_status       (m_status)
    );

    crc16_result_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_byte    (s_data_byte),
        .s_last_byte    (s_last_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_crc_value    (m_crc_value),
        .m_stored_value (m_stored_value),
        .m_status       (m_status),
        .failures       (fail_cnt),
        .outstanding    (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Run limit
    initial begin
        #5ms;
        $display("tb_top: errors");
        $finish;
    end

    // Result side: random ready, or a long hold-off when one is requested
    initial begin
        forever begin
            @(posedge aclk);
            if (stall_asked != stall_done) begin
                m_ready <= 1'b0;
                repeat (48) @(posedge aclk);
                stall_done++;
            end else begin
                m_ready <= ($urandom_range(99) >= rcv_idle_pct);
            end
        end
    end

    function automatic logic [7:0] rand_byte();
        int pick;
        pick = $urandom_range(19);
        if (pick == 0) return 8'h00;
        if (pick == 1) return 8'hFF;
        return 8'($urandom_range(255));
    endfunction

    // One byte beat; returns at the edge that accepts it
    task automatic put_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < snd_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_data_byte <= b;
        s_last_byte <= last;
        do @(posedge aclk); while (!s_ready);
        bytes_sent++;
    endtask

    // Mode write once every expected result is out and the core has settled
    task automatic write_mode(input logic m);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= m;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cur_mode = m;
    endtask

    // Body plus its own CRC as a little-endian trailer, optionally broken
    task automatic send_checked(input int body_len, input bit corrupt);
        logic [15:0] c;
        logic [7:0]  b;
        c = CRC_START;
        for (int i = 0; i < body_len; i++) begin
            b = rand_byte();
            c = crc_add_byte(c, b);
            put_byte(b, 1'b0);
        end
        if (corrupt) c ^= 16'(1) << $urandom_range(15);
        put_byte(c[7:0], 1'b0);
        put_byte(c[15:8], 1'b1);
    endtask

    task automatic random_block(input int quota);
        int start_cnt;
        int kind;
        int len;
        start_cnt = bytes_sent;
        while (bytes_sent - start_cnt < quota) begin
            kind = $urandom_range(99);
            if (cur_mode == MODE_CHECK && kind < 75) begin
                len = ($urandom_range(9) == 0) ? $urandom_range(7, 24) : $urandom_range(0, 6);
                send_checked(len, kind < 10);
            end else begin
                len = ($urandom_range(9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
                for (int i = 0; i < len; i++) put_byte(rand_byte(), i == len - 1);
            end
        end
        // sometimes leave a message open across the next mode write
        if ($urandom_range(2) == 0) begin
            len = $urandom_range(1, 3);
            repeat (len) put_byte(rand_byte(), 1'b0);
        end
    endtask

    // Stimulus and verdict
    initial begin
        logic [15:0] trailer;
        int          blk;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        snd_idle_pct = 30;
        rcv_idle_pct = 54;

        // Compute mode: byte extremes, one- and three-byte messages
        write_mode(MODE_COMPUTE);
        put_byte(8'h00, 1'b1);
        put_byte(8'hFF, 1'b1);
        put_byte(8'h01, 1'b0);
        put_byte(8'h80, 1'b0);
        put_byte(8'h5A, 1'b1);

        // Check mode: one byte is too short, two bytes are all trailer
        write_mode(MODE_CHECK);
        put_byte(8'hA5, 1'b1);
        put_byte(8'h12, 1'b0);
        put_byte(8'h34, 1'b1);
        put_byte(8'hFF, 1'b0);
        put_byte(8'hFF, 1'b1);

        // Check mode: matching trailer, body rolls through the hold buffer
        trailer = crc_add_byte(crc_add_byte(CRC_START, 8'h31), 8'h32);
        put_byte(8'h31, 1'b0);
        put_byte(8'h32, 1'b0);
        put_byte(trailer[7:0], 1'b0);
        put_byte(trailer[15:8], 1'b1);

        // Into compute mid-message: held bytes are dropped uncovered
        put_byte(8'h11, 1'b0);
        put_byte(8'h22, 1'b0);
        write_mode(MODE_COMPUTE);
        put_byte(8'h33, 1'b1);

        // Into check mid-message: bytes already folded stay in the CRC
        put_byte(8'h44, 1'b0);
        write_mode(MODE_CHECK);
        put_byte(8'h55, 1'b0);
        put_byte(8'h66, 1'b0);
        put_byte(8'h77, 1'b1);

        // Random phases: receiver-heavy idling, sender-heavy, then none
        for (int ph = 0; ph < 3; ph++) begin
            snd_idle_pct = (ph == 0) ? 30 : (ph == 1) ? 54 : 0;
            rcv_idle_pct = (ph == 0) ? 54 : (ph == 1) ? 30 : 0;
            for (blk = 0; blk < 8; blk++) begin
                write_mode((blk < 2) ? blk[0] : ($urandom_range(1) == 1));
                if (ph == 2 && blk == 0) begin
                    // hold results off while single-byte messages pile up
                    stall_asked++;
                    repeat (8) put_byte(rand_byte(), 1'b1);
                end
                random_block(66);
            end
        end

        // Drain
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (fail_cnt == 0 && pending == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
